// ----- hw/rtl/joint_impedance_torque_step_defines.svh -----
// Assertion macros used by the checker file.
`ifndef JOINT_IMPEDANCE_TORQUE_STEP_DEFINES_SVH
`define JOINT_IMPEDANCE_TORQUE_STEP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define JITS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jits assertion failed");

// Property that must also hold while reset is asserted.
`define JITS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("jits assertion failed");

`endif

// ----- hw/rtl/jits_pkg.sv -----
`default_nettype none

package jits_pkg;

   localparam int JOINT_COUNT = 8;
   localparam int JOINT_W     = 3;
   localparam logic [JOINT_W:0] JOINT_LIMIT = (JOINT_W + 1)'(JOINT_COUNT);

   localparam logic [16:0] ALPHA_ONE   = 17'd65536;
   localparam logic [16:0] ALPHA_RESET = 17'd0;
   localparam logic [30:0] STEP_RESET  = 31'h7FFF_FFFF;

   // configuration register indexes
   localparam logic [0:0] REG_ALPHA = 1'b0;
   localparam logic [0:0] REG_STEP  = 1'b1;

   // filter lanes
   localparam int LANE_K = 0;
   localparam int LANE_D = 1;
   localparam int LANE_P = 2;
   localparam int LANE_V = 3;
   localparam int LANES  = 4;

   localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
   localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;
   localparam logic signed [50:0] HALF_LSB51 = 51'sd32768;
   localparam logic signed [64:0] HALF_LSB65 = 65'sd32768;

   typedef struct packed {
      logic [JOINT_W-1:0]  joint;
      logic signed [31:0]  q;
      logic signed [31:0]  dq;
      logic signed [31:0]  cor;
      logic                cok;
      logic signed [31:0]  cq;
      logic signed [31:0]  cdq;
      logic [30:0]         ck;
      logic [30:0]         cd;
      logic signed [31:0]  cff;
   } item_type;

   typedef struct packed {
      logic signed [31:0] last;
      logic signed [31:0] held;
      logic signed [31:0] fvel;
      logic signed [31:0] fpos;
      logic signed [31:0] fdamp;
      logic signed [31:0] fstiff;
   } state_type;

   typedef struct packed {
      logic               en;
      logic [JOINT_W-1:0] addr;
      state_type          data;
   } wr_type;

   typedef struct packed {
      logic               valid;
      logic [JOINT_W-1:0] joint;
      logic signed [31:0] torque;
      logic               ok;
   } res_type;

   function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
      logic signed [31:0] r;
      if (x > SAT_MAX) begin
         r = SAT_MAX[31:0];
      end else if (x < SAT_MIN) begin
         r = SAT_MIN[31:0];
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Q1.16 weight times Q16.16 value, exact
   function automatic logic signed [49:0] wmul(input logic [16:0] w,
                                               input logic signed [31:0] v);
      logic signed [17:0] ws;
      ws = $signed({1'b0, w});
      return 50'(ws) * 50'(v);
   endfunction

   // sum of two weighted terms, round half up to Q16.16, saturate
   function automatic logic signed [31:0] blend_round(input logic signed [49:0] pa,
                                                      input logic signed [49:0] pb);
      logic signed [50:0] acc;
      logic signed [34:0] r;
      acc = 51'(pa) + 51'(pb) + HALF_LSB51;
      r   = acc[50:16];
      return sat35(r);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jits_state_mem.sv -----
`default_nettype none

module jits_state_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [jits_pkg::JOINT_W-1:0]  rd_addr,
   input  wire jits_pkg::wr_type              wr,
   output jits_pkg::state_type                rd_data,
   output logic                               rd_started
);

   jits_pkg::state_type mem_ff [jits_pkg::JOINT_COUNT];
   jits_pkg::state_type rd_data_ff;
   logic [jits_pkg::JOINT_COUNT-1:0] started_ff;
   logic rd_started_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff    <= mem_ff[rd_addr];
         rd_started_ff <= started_ff[rd_addr];
      end
   end

   // a joint counts as started once its first valid item is written back
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
      end else if (wr.en) begin
         started_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_started = rd_started_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/jits_law.sv -----
`default_nettype none

module jits_law (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          accept,
   input  wire jits_pkg::item_type            item,
   input  wire logic [16:0]                   alpha,
   input  wire logic [30:0]                   step,
   input  wire jits_pkg::state_type           rd_data,
   input  wire logic                          rd_started,
   input  wire logic [jits_pkg::JOINT_W-1:0]  probe_joint,
   output logic                               hazard,
   output jits_pkg::wr_type                   wr,
   output jits_pkg::res_type                  res
);

   localparam int L = jits_pkg::LANES;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // S1: state read back, select and error
   jits_pkg::item_type it1_ff;
   logic signed [31:0] old_in [L];
   logic signed [31:0] cmd_in [L];
   logic signed [31:0] held_in, last_in;
   logic signed [32:0] ep_in, ev_in;
   logic [16:0] a_in, na_in;
   logic ok_in;

   // S2: multiply
   logic [jits_pkg::JOINT_W-1:0] j2_ff;
   logic ok2_ff;
   logic signed [31:0] cor2_ff, held2_ff, last2_ff, cff2_ff;
   logic signed [31:0] old2_ff [L];
   logic signed [31:0] cmd2_ff [L];
   logic signed [32:0] ep2_ff, ev2_ff;
   logic [16:0] a2_ff, na2_ff;
   logic signed [64:0] mk_in, md_in;
   logic signed [49:0] nb_in [L];
   logic signed [49:0] ob_in [L];

   // S3: round and sum
   logic [jits_pkg::JOINT_W-1:0] j3_ff;
   logic ok3_ff;
   logic signed [31:0] cor3_ff, held3_ff, last3_ff, cff3_ff;
   logic signed [64:0] mk3_ff, md3_ff;
   logic signed [49:0] nb3_ff [L];
   logic signed [49:0] ob3_ff [L];
   logic signed [64:0] mkr, mdr;
   logic signed [48:0] rk, rd;
   logic signed [50:0] tau_in;
   logic signed [31:0] nf_in [L];

   // S4: rate limit
   logic [jits_pkg::JOINT_W-1:0] j4_ff;
   logic ok4_ff;
   logic signed [50:0] tau4_ff;
   logic signed [31:0] last4_ff, cff4_ff;
   logic signed [31:0] nf4_ff [L];
   logic signed [51:0] diff, lim, nlim;
   logic signed [31:0] dc_in;

   // S5: final add, write back
   logic [jits_pkg::JOINT_W-1:0] j5_ff;
   logic ok5_ff;
   logic signed [31:0] dc5_ff, last5_ff, cff5_ff;
   logic signed [31:0] nf5_ff [L];
   logic signed [32:0] sum5;
   logic signed [31:0] torque_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // any joint still between read and write back blocks a new item for it
   assign hazard = (v1_ff && it1_ff.joint == probe_joint) ||
                   (v2_ff && j2_ff == probe_joint) ||
                   (v3_ff && j3_ff == probe_joint) ||
                   (v4_ff && j4_ff == probe_joint) ||
                   (v5_ff && j5_ff == probe_joint);

   // ---- S1
   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff <= item;
      end
   end

   always_comb begin
      cmd_in[jits_pkg::LANE_K] = $signed({1'b0, it1_ff.ck});
      cmd_in[jits_pkg::LANE_D] = $signed({1'b0, it1_ff.cd});
      cmd_in[jits_pkg::LANE_P] = it1_ff.cq;
      cmd_in[jits_pkg::LANE_V] = it1_ff.cdq;
      // first item of a joint loads its targets straight from the command
      if (rd_started) begin
         old_in[jits_pkg::LANE_K] = rd_data.fstiff;
         old_in[jits_pkg::LANE_D] = rd_data.fdamp;
         old_in[jits_pkg::LANE_P] = rd_data.fpos;
         old_in[jits_pkg::LANE_V] = rd_data.fvel;
         held_in = rd_data.held;
         last_in = rd_data.last;
      end else begin
         for (int i = 0; i < L; i++) begin
            old_in[i] = cmd_in[i];
         end
         held_in = it1_ff.cff;
         last_in = '0;
      end
      ep_in = 33'(old_in[jits_pkg::LANE_P]) - 33'(it1_ff.q);
      ev_in = 33'(old_in[jits_pkg::LANE_V]) - 33'(it1_ff.dq);
      a_in  = (alpha > jits_pkg::ALPHA_ONE) ? jits_pkg::ALPHA_ONE : alpha;
      na_in = jits_pkg::ALPHA_ONE - a_in;
      ok_in = it1_ff.cok && ({1'b0, it1_ff.joint} < jits_pkg::JOINT_LIMIT);
   end

   // ---- S2
   always_ff @(posedge clock) begin
      if (adv) begin
         j2_ff    <= it1_ff.joint;
         ok2_ff   <= ok_in;
         cor2_ff  <= it1_ff.cor;
         held2_ff <= held_in;
         last2_ff <= last_in;
         cff2_ff  <= it1_ff.cff;
         ep2_ff   <= ep_in;
         ev2_ff   <= ev_in;
         a2_ff    <= a_in;
         na2_ff   <= na_in;
         for (int i = 0; i < L; i++) begin
            old2_ff[i] <= old_in[i];
            cmd2_ff[i] <= cmd_in[i];
         end
      end
   end

   always_comb begin
      mk_in = 65'(old2_ff[jits_pkg::LANE_K]) * 65'(ep2_ff);
      md_in = 65'(old2_ff[jits_pkg::LANE_D]) * 65'(ev2_ff);
      for (int i = 0; i < L; i++) begin
         nb_in[i] = jits_pkg::wmul(na2_ff, cmd2_ff[i]);
         ob_in[i] = jits_pkg::wmul(a2_ff, old2_ff[i]);
      end
   end

   // ---- S3
   always_ff @(posedge clock) begin
      if (adv) begin
         j3_ff    <= j2_ff;
         ok3_ff   <= ok2_ff;
         cor3_ff  <= cor2_ff;
         held3_ff <= held2_ff;
         last3_ff <= last2_ff;
         cff3_ff  <= cff2_ff;
         mk3_ff   <= mk_in;
         md3_ff   <= md_in;
         for (int i = 0; i < L; i++) begin
            nb3_ff[i] <= nb_in[i];
            ob3_ff[i] <= ob_in[i];
         end
      end
   end

   always_comb begin
      mkr    = mk3_ff + jits_pkg::HALF_LSB65;
      mdr    = md3_ff + jits_pkg::HALF_LSB65;
      rk     = mkr[64:16];
      rd     = mdr[64:16];
      tau_in = 51'(cor3_ff) + 51'(rk) + 51'(rd) + 51'(held3_ff);
      for (int i = 0; i < L; i++) begin
         nf_in[i] = jits_pkg::blend_round(nb3_ff[i], ob3_ff[i]);
      end
   end

   // ---- S4
   always_ff @(posedge clock) begin
      if (adv) begin
         j4_ff    <= j3_ff;
         ok4_ff   <= ok3_ff;
         tau4_ff  <= tau_in;
         last4_ff <= last3_ff;
         cff4_ff  <= cff3_ff;
         for (int i = 0; i < L; i++) begin
            nf4_ff[i] <= nf_in[i];
         end
      end
   end

   always_comb begin
      diff = 52'(tau4_ff) - 52'(last4_ff);
      lim  = 52'({1'b0, step});
      nlim = -lim;
      priority if (diff > lim) begin
         dc_in = lim[31:0];
      end else if (diff < nlim) begin
         dc_in = nlim[31:0];
      end else begin
         dc_in = diff[31:0];
      end
   end

   // ---- S5
   always_ff @(posedge clock) begin
      if (adv) begin
         j5_ff    <= j4_ff;
         ok5_ff   <= ok4_ff;
         dc5_ff   <= dc_in;
         last5_ff <= last4_ff;
         cff5_ff  <= cff4_ff;
         for (int i = 0; i < L; i++) begin
            nf5_ff[i] <= nf4_ff[i];
         end
      end
   end

   always_comb begin
      sum5      = 33'(last5_ff) + 33'(dc5_ff);
      torque_in = ok5_ff ? jits_pkg::sat35(35'(sum5)) : '0;
   end

   always_comb begin
      wr.en          = adv && v5_ff && ok5_ff;
      wr.addr        = j5_ff;
      wr.data.last   = torque_in;
      wr.data.held   = cff5_ff;
      wr.data.fvel   = nf5_ff[jits_pkg::LANE_V];
      wr.data.fpos   = nf5_ff[jits_pkg::LANE_P];
      wr.data.fdamp  = nf5_ff[jits_pkg::LANE_D];
      wr.data.fstiff = nf5_ff[jits_pkg::LANE_K];
      res.valid      = v5_ff;
      res.joint      = j5_ff;
      res.torque     = torque_in;
      res.ok         = ok5_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/joint_impedance_torque_step.sv -----
// Channel   Direction  Handshake            Payload
// req_*     in         req_valid/req_ready  joint, measured state, Coriolis, command
// rsp_*     out        rsp_valid/rsp_ready  joint, drive torque, ok
// csr_*     in         csr_write_en         register index, write data
//
// One item per cycle while no result is held and each item's joint differs from every joint still in the pipeline.
// An accepted item passes through five stages, the first loaded at acceptance, and then
// through the output register that drives rsp_valid.
// An item for a joint still in the per-joint state read-modify-write loop waits.
// Synchronous reset clears started flags at once; no memory clearing pass.
// A held result stalls the whole pipeline; req_ready falls with it.
`default_nettype none

module joint_impedance_torque_step (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [2:0]                    req_joint_index,
   input  wire logic signed [31:0]            req_meas_position,
   input  wire logic signed [31:0]            req_meas_velocity,
   input  wire logic signed [31:0]            req_coriolis_torque,
   input  wire logic                          req_coriolis_ok,
   input  wire logic signed [31:0]            req_target_position,
   input  wire logic signed [31:0]            req_target_velocity,
   input  wire logic [30:0]                   req_target_stiffness,
   input  wire logic [30:0]                   req_target_damping,
   input  wire logic signed [31:0]            req_target_ff_torque,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_out_joint,
   output logic signed [31:0]                 rsp_drive_torque,
   output logic                               rsp_ok,

   input  wire logic                          csr_write_en,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [30:0]                   csr_write_data
);

   logic [16:0] alpha_ff;
   logic [30:0] step_ff;
   logic rsp_valid_ff;
   logic [2:0] rsp_joint_ff;
   logic signed [31:0] rsp_torque_ff;
   logic rsp_ok_ff;

   logic adv, accept, hazard;
   jits_pkg::item_type item;
   jits_pkg::state_type rd_data;
   logic rd_started;
   jits_pkg::wr_type wr;
   jits_pkg::res_type res;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !hazard;
   assign accept    = req_valid && req_ready;

   always_comb begin
      item.joint = req_joint_index;
      item.q     = req_meas_position;
      item.dq    = req_meas_velocity;
      item.cor   = req_coriolis_torque;
      item.cok   = req_coriolis_ok;
      item.cq    = req_target_position;
      item.cdq   = req_target_velocity;
      item.ck    = req_target_stiffness;
      item.cd    = req_target_damping;
      item.cff   = req_target_ff_torque;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= jits_pkg::ALPHA_RESET;
         step_ff  <= jits_pkg::STEP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            jits_pkg::REG_ALPHA: alpha_ff <= csr_write_data[16:0];
            jits_pkg::REG_STEP:  step_ff  <= csr_write_data;
         endcase
      end
   end

   jits_state_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (adv),
      .rd_addr    (req_joint_index),
      .wr         (wr),
      .rd_data    (rd_data),
      .rd_started (rd_started)
   );

   jits_law u_law (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .item        (item),
      .alpha       (alpha_ff),
      .step        (step_ff),
      .rd_data     (rd_data),
      .rd_started  (rd_started),
      .probe_joint (req_joint_index),
      .hazard      (hazard),
      .wr          (wr),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_joint_ff  <= res.joint;
         rsp_torque_ff <= res.torque;
         rsp_ok_ff     <= res.ok;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_joint    = rsp_joint_ff;
   assign rsp_drive_torque = rsp_torque_ff;
   assign rsp_ok           = rsp_ok_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/jits_checker.sv -----
`default_nettype none
`include "joint_impedance_torque_step_defines.svh"

module jits_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_ok,
   input wire logic signed [31:0] rsp_drive_torque
);

   // a refused item carries zero torque
   `JITS_ASSERT(a_fail_zero, clock, reset, (rsp_valid && !rsp_ok) |-> (rsp_drive_torque == '0))

   // nothing enters while a result is held back
   `JITS_ASSERT(a_stall_blocks, clock, reset, (rsp_valid && !rsp_ready) |-> !(req_valid && req_ready))

   `JITS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive_torque) && $stable(rsp_ok)))

   `JITS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind joint_impedance_torque_step jits_checker u_jits_checker (.*);

`default_nettype wire

// ----- bench/joint_impedance_torque_step_tb.sv -----
`timescale 1ns / 1ps

module joint_impedance_torque_step_tb;
   import jits_pkg::*;

   typedef struct packed {
      logic [2:0]         joint;
      logic signed [31:0] torque;
      logic               ok;
   } drive_result_type;

   localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
   localparam logic [30:0]        G_MAX = 31'h7fff_ffff;
   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint I32_MIN = -64'sd2147483648;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 190;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   item_type    req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_out_joint;
   logic signed [31:0] rsp_drive_torque;
   logic        rsp_ok;
   logic        csr_write_en = 1'b0;
   logic [0:0]  csr_index = REG_ALPHA;
   logic [30:0] csr_write_data = '0;

   joint_impedance_torque_step i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_joint_index      (req_item.joint),
      .req_meas_position    (req_item.q),
      .req_meas_velocity    (req_item.dq),
      .req_coriolis_torque  (req_item.cor),
      .req_coriolis_ok      (req_item.cok),
      .req_target_position  (req_item.cq),
      .req_target_velocity  (req_item.cdq),
      .req_target_stiffness (req_item.ck),
      .req_target_damping   (req_item.cd),
      .req_target_ff_torque (req_item.cff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_joint        (rsp_out_joint),
      .rsp_drive_torque     (rsp_drive_torque),
      .rsp_ok               (rsp_ok),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // predictor state, one entry per joint
   logic               started [JOINT_COUNT];
   logic signed [31:0] filt_k  [JOINT_COUNT];
   logic signed [31:0] filt_d  [JOINT_COUNT];
   logic signed [31:0] filt_p  [JOINT_COUNT];
   logic signed [31:0] filt_v  [JOINT_COUNT];
   logic signed [31:0] held_ff [JOINT_COUNT];
   logic signed [31:0] last_tq [JOINT_COUNT];
   logic [16:0]        cfg_alpha = ALPHA_RESET;
   logic [30:0]        cfg_step  = STEP_RESET;

   item_type         pending_items[$];
   drive_result_type expected_torques[$];

   bit req_fire  = 1'b0;
   bit idle_en   = 1'b1;
   bit long_hold = 1'b0;
   int tx_gap    = 0;
   int hold_left = 0;
   int errors    = 0;
   int items_taken = 0;
   int invalid_taken = 0;
   int torques_checked = 0;
   int settings_used = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic longint round_q16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic logic signed [31:0] clip32(input longint x);
      if (x > I32_MAX) begin
         return W_MAX;
      end else if (x < I32_MIN) begin
         return W_MIN;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] blend_target(input longint cmd,
                                                       input logic signed [31:0] old,
                                                       input longint a);
      longint acc;
      acc = (64'sd65536 - a) * cmd + a * longint'(old);
      return clip32(round_q16(acc));
   endfunction

   task automatic predict_drive_torque(input item_type it);
      drive_result_type res;
      longint a, lim, tau, diff;
      int j;
      j = int'(it.joint);
      res.joint  = it.joint;
      res.torque = '0;
      res.ok     = 1'b0;
      if (it.cok && j < JOINT_COUNT) begin
         if (!started[j]) begin
            filt_p[j]  = it.cq;
            filt_v[j]  = it.cdq;
            filt_k[j]  = {1'b0, it.ck};
            filt_d[j]  = {1'b0, it.cd};
            held_ff[j] = it.cff;
            last_tq[j] = '0;
            started[j] = 1'b1;
         end
         tau = longint'(it.cor)
             + round_q16(longint'(filt_k[j]) * (longint'(filt_p[j]) - longint'(it.q)))
             + round_q16(longint'(filt_d[j]) * (longint'(filt_v[j]) - longint'(it.dq)))
             + longint'(held_ff[j]);
         lim  = longint'(cfg_step);
         diff = tau - longint'(last_tq[j]);
         if (diff > lim) diff = lim;
         if (diff < -lim) diff = -lim;
         res.torque = clip32(longint'(last_tq[j]) + diff);
         res.ok     = 1'b1;
         last_tq[j] = res.torque;
         held_ff[j] = it.cff;
         a = (cfg_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(cfg_alpha);
         filt_k[j] = blend_target(longint'(it.ck), filt_k[j], a);
         filt_d[j] = blend_target(longint'(it.cd), filt_d[j], a);
         filt_p[j] = blend_target(longint'(it.cq), filt_p[j], a);
         filt_v[j] = blend_target(longint'(it.cdq), filt_v[j], a);
      end
      expected_torques.push_back(res);
   endtask

   function automatic void flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_en || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h0000_0000;
               1: return 32'hffff_ffff;
               2: return 32'h8000_0000;
               3: return 32'h7fff_ffff;
               default: return 32'h0000_0001;
            endcase
         end
         1, 2, 3, 4: return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [30:0] pick_gain();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 2))
               0: return 31'h0;
               1: return G_MAX;
               default: return 31'h1;
            endcase
         end
         1, 2, 3, 4, 5: return 31'($urandom_range(0, 32'h000f_ffff));
         default: return 31'($urandom());
      endcase
   endfunction

   function automatic item_type make_item(input logic [2:0] joint);
      item_type it;
      it.joint = joint;
      it.q     = pick_word();
      it.dq    = pick_word();
      it.cor   = pick_word();
      it.cok   = ($urandom_range(0, 9) != 0);
      it.cq    = pick_word();
      it.cdq   = pick_word();
      it.ck    = pick_gain();
      it.cd    = pick_gain();
      it.cff   = pick_word();
      return it;
   endfunction

   function automatic item_type directed_item(input logic [2:0] joint,
         input logic signed [31:0] q, dq, cor, input logic cok,
         input logic signed [31:0] cq, cdq, input logic [30:0] ck, cd,
         input logic signed [31:0] cff);
      item_type it;
      it.joint = joint;
      it.q = q;   it.dq = dq;   it.cor = cor;   it.cok = cok;
      it.cq = cq; it.cdq = cdq; it.ck = ck;     it.cd = cd;
      it.cff = cff;
      return it;
   endfunction

   task automatic write_reg(input logic [0:0] idx, input logic [30:0] val);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_ALPHA) begin
         cfg_alpha = val[16:0];
      end else begin
         cfg_step = val;
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_torques.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // sender: one item offered at a time, held until taken
   always @(negedge clock) begin : feed
      if (req_fire || !req_valid) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_item  <= pending_items.pop_front();
            req_valid <= 1'b1;
            tx_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_fire = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin : drain
      int unsigned roll;
      if (long_hold) begin
         hold_left = 400;
         long_hold = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!idle_en) begin
         rsp_ready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            hold_left = $urandom_range(8, 40);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (roll >= 25);
         end
      end
   end

   always @(posedge clock) begin : watch
      drive_result_type want;
      if (!reset && req_valid && req_ready) begin
         predict_drive_torque(req_item);
         items_taken++;
         if (!req_item.cok) invalid_taken++;
         req_fire = 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_torques.size() == 0) begin
            flag_error($sformatf("unexpected item: joint %0d torque %0d ok %0b",
                                 rsp_out_joint, rsp_drive_torque, rsp_ok));
         end else begin
            want = expected_torques.pop_front();
            torques_checked++;
            if (rsp_out_joint !== want.joint || rsp_drive_torque !== want.torque ||
                rsp_ok !== want.ok) begin
               flag_error($sformatf(
                  "joint %0d/%0d torque %0d/%0d ok %0b/%0b (expected/actual)",
                  want.joint, rsp_out_joint, want.torque, rsp_drive_torque,
                  want.ok, rsp_ok));
            end
         end
      end
   end

   initial begin : stimulus
      logic [2:0]  jnt;
      logic [30:0] alpha_val, step_val;
      int waited;
      for (int i = 0; i < JOINT_COUNT; i++) started[i] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // invalid Coriolis before the joint has started leaves it unstarted
      pending_items.push_back(directed_item(0, W_MIN, W_MIN, W_MAX, 1'b0,
                                            W_MAX, W_MAX, G_MAX, G_MAX, W_MAX));
      // huge positive demand: rate limit, then saturation at the top
      repeat (2) pending_items.push_back(directed_item(0, W_MIN, W_MIN, W_MAX, 1'b1,
                                                       W_MAX, W_MAX, G_MAX, G_MAX, W_MAX));
      // and down to the bottom
      repeat (4) pending_items.push_back(directed_item(0, W_MAX, W_MAX, W_MIN, 1'b1,
                                                       W_MIN, W_MIN, G_MAX, G_MAX, W_MIN));
      pending_items.push_back(directed_item(0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0));
      for (int j = 1; j < JOINT_COUNT; j++) begin
         pending_items.push_back(directed_item(3'(j), j << 16, -(j << 15), j << 12, 1'b1,
                                               -(j << 16), j << 14, 31'(j << 15),
                                               31'(j << 13), -(j << 10)));
      end
      // rounding ties: +0.5 rounds up, -0.5 rounds to zero
      pending_items.push_back(directed_item(4, 0, 0, 0, 1'b1, 0, 0, 31'h8000, 31'h8000, 0));
      pending_items.push_back(directed_item(4, -1, 1, 0, 1'b1, 0, 0, 31'h8000, 31'h8000, 0));
      pending_items.push_back(directed_item(3, 32'sh0001_0000, -32'sh0001_0000, 0, 1'b1,
                                            0, 0, 0, 0, 0));
      pending_items.push_back(directed_item(7, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0));
      pending_items.push_back(directed_item(5, -1, 1, -1, 1'b1, 1, -1, 1, 1, -1));

      jnt = '0;
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin alpha_val = 31'd0;                  step_val = STEP_RESET;  end
            1: begin alpha_val = {14'h0, ALPHA_ONE};     step_val = 31'd0;       end
            2: begin alpha_val = 31'h7fff_ffff;          step_val = 31'd1;       end
            3: begin
               alpha_val = {14'($urandom()), 17'd32768};
               step_val  = 31'($urandom_range(1, 32'h0010_0000));
            end
            4: begin
               alpha_val = 31'($urandom_range(0, 65536));
               step_val  = 31'($urandom());
            end
            default: begin alpha_val = 31'd1;            step_val = G_MAX;       end
         endcase
         write_reg(REG_ALPHA, alpha_val);
         write_reg(REG_STEP, step_val);
         settings_used++;
         @(posedge clock);
         idle_en = (p != 1 && p != 4);
         // the block fills up and must stall its input
         if (p == 1) long_hold = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 9) >= 3) jnt = 3'($urandom_range(0, JOINT_COUNT - 1));
            pending_items.push_back(make_item(jnt));
         end
      end

      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (expected_torques.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (expected_torques.size() != 0) begin
         flag_error($sformatf("%0d torques never arrived", expected_torques.size()));
      end

      $display("Run covered %0d items (%0d with invalid Coriolis) over %0d settings,",
               items_taken, invalid_taken, settings_used);
      $display("%0d torques checked, %0d mismatches.", torques_checked, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/jits_pkg.sv
hw/rtl/jits_state_mem.sv
hw/rtl/jits_law.sv
hw/rtl/joint_impedance_torque_step.sv
hw/rtl/jits_checker.sv
bench/joint_impedance_torque_step_tb.sv
